// File: src/sha256_pkg.sv
// Package for the SHA-256 stream hash: commands, round constants and round functions.
// Depends on nothing; used by the engine, the controller and the top level.
`default_nettype none
package sha256_pkg;

    typedef enum logic [1:0] {
        CMD_ABSORB        = 2'd0,
        CMD_ABSORB_FINISH = 2'd1,
        CMD_FINISH        = 2'd2,
        CMD_UNUSED        = 2'd3
    } t_cmd;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Request from the controller to the round engine.
    typedef struct packed {
        logic start;
        logic load_init;
    } t_eng_req;

    function automatic logic [31:0] f_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] f_h_init(input logic [2:0] idx);
        logic [31:0] h;
        case (idx)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic logic [31:0] f_rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] f_sig0(input logic [31:0] x);
        return f_rotr(x, 7) ^ f_rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] f_sig1(input logic [31:0] x);
        return f_rotr(x, 17) ^ f_rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage
`default_nettype wire

// File: src/sha256_engine.sv
// Round engine: block words in a 16-entry memory, one SHA-256 round per cycle from
// round 16 on, chaining words in registers. Depends on sha256_pkg.
`default_nettype none
module sha256_engine
    import sha256_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_eng_req    i_req,
    // Word write port from the controller (byte lanes, big-endian in word).
    input  wire logic        i_wr_en,
    input  wire logic [3:0]  i_wr_addr,
    input  wire logic [1:0]  i_wr_lane,
    input  wire logic [7:0]  i_wr_byte,
    input  wire logic        i_wr_clear,
    output logic             o_busy,
    input  wire logic [2:0]  i_h_sel,
    output logic [31:0]      o_h_word
);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_ROUND, S_ADD} t_state;

    // Schedule memory: 16 words, one write and one registered read per cycle.
    logic [31:0] r_wmem [16];
    logic [31:0] r_rd;
    logic [3:0]  n_rd_addr;

    t_state      r_state;
    logic [5:0]  r_round;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];   // rolling schedule window as shift line
    logic [31:0] w_cur;
    logic [31:0] t1, t2, s0, s1, ch, mj;

    assign n_rd_addr = r_round[3:0];

    // Byte-lane writes. A write to lane 0 clears the rest of the word, so the
    // bytes past the fill point of a word never hold data of an earlier block.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            if (i_wr_clear) r_wmem[i_wr_addr] <= '0;
            else if (i_wr_lane == 2'd0) r_wmem[i_wr_addr] <= {i_wr_byte, 24'd0};
            else r_wmem[i_wr_addr][8*(3-i_wr_lane) +: 8] <= i_wr_byte;
        end
        r_rd <= r_wmem[n_rd_addr];
    end

    // Schedule word of the current round.
    always_comb begin
        if (r_round < 6'd16) w_cur = r_rd;
        else w_cur = f_sig1(r_w[14]) + r_w[9] + f_sig0(r_w[1]) + r_w[0];
        s1 = f_rotr(r_v[4], 6) ^ f_rotr(r_v[4], 11) ^ f_rotr(r_v[4], 25);
        ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1 = r_v[7] + s1 + ch + f_k(r_round) + w_cur;
        s0 = f_rotr(r_v[0], 2) ^ f_rotr(r_v[0], 13) ^ f_rotr(r_v[0], 22);
        mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2 = s0 + mj;
    end

    // Sequencer and round registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_round <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= f_h_init(3'(i));
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req.load_init) begin
                        for (int i = 0; i < 8; i++) r_h[i] <= f_h_init(3'(i));
                    end
                    if (i_req.start) begin
                        r_round <= '0;
                        for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_ROUND;
                S_ROUND: begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= w_cur;
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'd63) r_state <= S_ADD;
                    else if (r_round < 6'd15) r_state <= S_READ;
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_h_word = r_h[i_h_sel];

endmodule
`default_nettype wire

// File: src/sha256_ctrl.sv
// Byte collection, padding and digest output sequencing for the stream hash.
// Depends on sha256_pkg; drives sha256_engine.
`default_nettype none
module sha256_ctrl
    import sha256_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [7:0]  i_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_out_word,
    output logic [2:0]       o_out_index,
    output logic             o_out_last,
    output t_eng_req         o_req,
    output logic             o_wr_en,
    output logic [3:0]       o_wr_addr,
    output logic [1:0]       o_wr_lane,
    output logic [7:0]       o_wr_byte,
    output logic             o_wr_clear,
    input  wire logic        i_busy,
    output logic [2:0]       o_h_sel,
    input  wire logic [31:0] i_h_word
);

    typedef enum logic [2:0] {
        S_IDLE, S_WAIT, S_PAD, S_ZERO, S_LEN, S_FINAL, S_OUT
    } t_state;

    t_state      r_state;
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    // Finish pending after a full-block compress; during padding, set when the
    // padded block without room for the length is sent to be compressed.
    logic        r_fin;
    logic [3:0]  r_cnt;
    logic [2:0]  r_idx;
    logic        r_go;
    logic        r_out_valid;
    logic [31:0] r_out_word;
    logic [2:0]  r_out_index;
    logic        r_init;

    logic acc;
    assign acc = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE) && !i_busy && !r_go;

    // Byte writes go straight to the engine memory.
    always_comb begin
        o_wr_en = 1'b0; o_wr_addr = r_fill[5:2]; o_wr_lane = r_fill[1:0];
        o_wr_byte = i_byte; o_wr_clear = 1'b0;
        case (r_state)
            S_IDLE: o_wr_en = acc && (i_cmd == CMD_ABSORB || i_cmd == CMD_ABSORB_FINISH);
            S_PAD: begin o_wr_en = 1'b1; o_wr_byte = PAD_BYTE; end
            S_ZERO: begin o_wr_en = 1'b1; o_wr_addr = r_cnt; o_wr_clear = 1'b1; end
            S_LEN: begin
                o_wr_en = 1'b1; o_wr_addr = {3'b111, r_cnt[2]}; o_wr_lane = r_cnt[1:0];
                o_wr_byte = r_bits[8*(7-r_cnt[2:0]) +: 8];
            end
            default: ;
        endcase
    end

    assign o_req.start     = r_go;
    assign o_req.load_init = r_init;
    assign o_h_sel         = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_fill <= '0; r_bits <= '0; r_fin <= 1'b0;
            r_go <= 1'b0; r_out_valid <= 1'b0; r_idx <= '0; r_init <= 1'b0;
            r_cnt <= '0; r_out_word <= '0; r_out_index <= '0;
        end else begin
            r_go <= 1'b0; r_init <= 1'b0;
            case (r_state)
                S_IDLE: if (acc) begin
                    if (i_cmd == CMD_ABSORB || i_cmd == CMD_ABSORB_FINISH) begin
                        r_bits <= r_bits + 64'd8;
                        r_fill <= r_fill + 6'd1;
                        r_fin  <= (i_cmd == CMD_ABSORB_FINISH);
                        if (r_fill == 6'd63) begin
                            r_go <= 1'b1; r_state <= S_WAIT;
                        end else if (i_cmd == CMD_ABSORB_FINISH) r_state <= S_PAD;
                    end else if (i_cmd == CMD_FINISH) r_state <= S_PAD;
                end
                S_WAIT: if (!r_go && !i_busy) begin
                    r_state <= r_fin ? S_PAD : S_IDLE;
                end
                // Pad byte, then zero the words after it.
                S_PAD: begin
                    r_fin <= 1'b0;
                    r_cnt <= r_fill[5:2] + 4'd1;
                    r_fill <= r_fill + 6'd1;
                    if (r_fill[5:2] == 4'd15) r_state <= S_FINAL;
                    else r_state <= S_ZERO;
                end
                S_ZERO: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_state <= S_FINAL;
                    end
                end
                // Room check: length goes in words 14 and 15. Without room the
                // padded block is compressed first and a zero block follows.
                S_FINAL: if (!r_go && !i_busy) begin
                    if (r_fin) begin
                        r_fin <= 1'b0; r_cnt <= 4'd0; r_state <= S_ZERO;
                        r_fill <= 6'd56;
                    end else if (r_fill > 6'd56 || r_fill == 6'd0) begin
                        r_fin <= 1'b1; r_go <= 1'b1;
                    end else begin
                        r_cnt <= 4'd0; r_state <= S_LEN;
                    end
                end
                S_LEN: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd7) begin
                        r_go <= 1'b1; r_state <= S_OUT; r_idx <= '0;
                    end
                end
                S_OUT: if (!r_go && !i_busy) begin
                    if (!r_out_valid || i_out_ready) begin
                        if (r_out_valid && o_out_last) begin
                            r_out_valid <= 1'b0; r_init <= 1'b1;
                            r_fill <= '0; r_bits <= '0; r_state <= S_IDLE;
                        end else begin
                            r_out_valid <= 1'b1; r_out_word <= i_h_word;
                            r_out_index <= r_idx; r_idx <= r_idx + 3'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_out_index = r_out_index;
    assign o_out_last  = (r_out_index == 3'd7);

endmodule
`default_nettype wire

// File: src/sha256_stream_hash.sv
// Top level of the SHA-256 stream hash; joins the controller and the round engine.
// Depends on sha256_pkg, sha256_ctrl and sha256_engine.
//
// Usage: one message byte per input transaction. s_axis_tdata[1:0] is the command
// (absorb, absorb then finish, finish), s_axis_tdata[9:2] the byte. Every 64th
// byte starts a compression (16 memory reads interleaved with the first 16
// rounds, then 48 rounds and the final add), and s_axis_tready stays low until
// it is done. A finish pads the block, writes the length and compresses; when the
// length does not fit, the padded block is compressed first and the length goes
// in an extra block. Eight digest transactions H0..H7 then follow on the master
// side, one per cycle while the receiver is ready, the last with tlast high.
// A stalled receiver holds the current word; the input stays blocked until all
// eight words are taken, then the chaining words return to the initial values.
// Reset clears fill count and bit length and loads the initial chaining words.
`default_nettype none
module sha256_stream_hash
    import sha256_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // [1:0] cmd, [9:2] data_byte, rest zero
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // [31:0] digest_word, [34:32] word_index
    output logic             m_axis_tlast   // last_word
);

    t_eng_req    w_req;
    logic        w_wr_en, w_wr_clear, w_busy;
    logic [3:0]  w_wr_addr;
    logic [1:0]  w_wr_lane;
    logic [7:0]  w_wr_byte;
    logic [2:0]  w_h_sel, w_idx;
    logic [31:0] w_h_word, w_word;

    sha256_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_cmd(s_axis_tdata[1:0]), .i_byte(s_axis_tdata[9:2]),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_out_word(w_word), .o_out_index(w_idx), .o_out_last(m_axis_tlast),
        .o_req(w_req), .o_wr_en(w_wr_en), .o_wr_addr(w_wr_addr),
        .o_wr_lane(w_wr_lane), .o_wr_byte(w_wr_byte), .o_wr_clear(w_wr_clear),
        .i_busy(w_busy), .o_h_sel(w_h_sel), .i_h_word(w_h_word)
    );

    sha256_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req),
        .i_wr_en(w_wr_en), .i_wr_addr(w_wr_addr), .i_wr_lane(w_wr_lane),
        .i_wr_byte(w_wr_byte), .i_wr_clear(w_wr_clear), .o_busy(w_busy),
        .i_h_sel(w_h_sel), .o_h_word(w_h_word)
    );

    assign m_axis_tdata = {5'd0, w_idx, w_word};

endmodule
`default_nettype wire

// File: src/sha256_checker.sv
// Port-level checker for the SHA-256 stream hash, bound to the top level.
// Depends on sha256_stream_hash ports only.
`default_nettype none
module sha256_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);
    // No input is taken while a digest is being delivered.
    a_no_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input accepted during output");
    // tlast marks exactly word 7.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd7)))
        else $error("tlast mismatch");
    // A stalled word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
endmodule

bind sha256_stream_hash sha256_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire

// File: test/tb.sv
// Testbench for sha256_stream_hash: streams byte messages in and checks every digest word.
// Depends on sha256_pkg and the RTL; a local SHA-256 predictor supplies expected words.
`default_nettype none
module tb;
    import sha256_pkg::*;

    typedef struct {
        t_cmd       cmd;
        logic [7:0] data;
    } t_byte_item;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [1:0] cmd, [9:2] data_byte, rest zero
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [31:0] digest_word, [34:32] word_index
    logic        m_axis_tlast;   // last_word

    t_byte_item   pending_bytes[$];
    t_digest_word digest_q[$];
    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_seq;
    int           hold_seen;
    int           hold_left;
    int           idle_cycles;
    bit           failed;

    // Predictor state.
    logic [31:0] hash_chain[8];
    logic [7:0]  msg_block[64];
    int          msg_fill;
    logic [63:0] msg_bit_len;

    localparam logic [31:0] ROUND_K[64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] CHAIN_INIT[8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    sha256_stream_hash u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void clear_state();
        hash_chain = CHAIN_INIT;
        foreach (msg_block[i]) msg_block[i] = 8'h00;
        msg_fill = 0;
        msg_bit_len = 64'd0;
    endfunction

    // One SHA-256 compression of msg_block into hash_chain.
    function automatic void compress_block();
        logic [31:0] v[8];
        logic [31:0] w[64];
        logic [31:0] t1;
        logic [31:0] t2;
        v = hash_chain;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
        for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_chain[i] += v[i];
    endfunction

    // Applies one accepted transaction and queues the digest words it yields.
    function automatic void predict_digest(input t_cmd cmd, input logic [7:0] data);
        t_digest_word dw;
        if (cmd == CMD_UNUSED) return;
        if (cmd != CMD_FINISH) begin
            msg_block[msg_fill] = data;
            msg_bit_len += 64'd8;
            msg_fill++;
            if (msg_fill == 64) begin
                compress_block();
                msg_fill = 0;
            end
        end
        if (cmd == CMD_ABSORB) return;
        msg_block[msg_fill] = 8'h80;
        for (int i = msg_fill + 1; i < 64; i++) msg_block[i] = 8'h00;
        if (msg_fill >= 56) begin
            compress_block();
            foreach (msg_block[i]) msg_block[i] = 8'h00;
        end
        for (int i = 0; i < 8; i++) msg_block[56+i] = msg_bit_len[63-8*i -: 8];
        compress_block();
        for (int i = 0; i < 8; i++) begin
            dw.word = hash_chain[i];
            dw.index = 3'(i);
            dw.last = (i == 7);
            digest_q = {digest_q, dw};
        end
        clear_state();
    endfunction

    // Sender: holds an offered transaction until it is taken.
    always @(posedge i_clk) begin
        t_byte_item it;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                predict_digest(t_cmd'(s_axis_tdata[1:0]), s_axis_tdata[9:2]);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    it = pending_bytes.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {6'd0, it.data, it.cmd};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls plus a long hold-off whenever hold_seq is bumped.
    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: compares each digest transaction with the oldest expected word.
    always @(posedge i_clk) begin
        t_digest_word exp_w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (digest_q.size() == 0) begin
                $error("unexpected digest transaction %h", m_axis_tdata);
                failed = 1'b1;
            end else begin
                exp_w = digest_q.pop_front();
                if (m_axis_tdata[31:0] !== exp_w.word) begin
                    $error("digest_word expected %h actual %h", exp_w.word, m_axis_tdata[31:0]);
                    failed = 1'b1;
                end
                if (m_axis_tdata[34:32] !== exp_w.index) begin
                    $error("word_index expected %0d actual %0d", exp_w.index,
                           m_axis_tdata[34:32]);
                    failed = 1'b1;
                end
                if (m_axis_tlast !== exp_w.last) begin
                    $error("last_word expected %0d actual %0d", exp_w.last, m_axis_tlast);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog: counts busy cycles in which no transaction moves.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (pending_bytes.size() == 0 && !s_axis_tvalid && digest_q.size() == 0)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic void queue_byte(input t_cmd cmd, input logic [7:0] data);
        t_byte_item it;
        it.cmd = cmd;
        it.data = data;
        pending_bytes = {pending_bytes, it};
    endfunction

    // One well-formed message with random bytes; short, or close to one block.
    function automatic void queue_message(input bit near_block);
        int len;
        if (near_block) len = 55 + $urandom_range(9);
        else len = $urandom_range(8);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(19) == 0) queue_byte(CMD_UNUSED, 8'($urandom));
            if (i == len - 1 && $urandom_range(1) == 0) queue_byte(CMD_ABSORB_FINISH, 8'($urandom));
            else queue_byte(CMD_ABSORB, 8'($urandom));
        end
        if (len == 0 || pending_bytes[$].cmd != CMD_ABSORB_FINISH)
            queue_byte(CMD_FINISH, 8'($urandom));
    endfunction

    // Checked between edges, once the sender and predictor have settled.
    task automatic wait_drained();
        while (pending_bytes.size() > 0 || s_axis_tvalid || digest_q.size() > 0)
            @(negedge i_clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items,
                             input bit near_block);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        if (near_block) queue_message(1'b1);
        while (pending_bytes.size() < n_items) queue_message(1'b0);
        wait_drained();
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_seq = 0;
        hold_seen = 0;
        hold_left = 0;
        idle_cycles = 0;
        failed = 1'b0;
        clear_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty message, ignored command, extreme bytes, short text.
        queue_byte(CMD_FINISH, 8'hff);
        queue_byte(CMD_UNUSED, 8'h5a);
        queue_byte(CMD_FINISH, 8'h00);
        queue_byte(CMD_ABSORB_FINISH, 8'h00);
        queue_byte(CMD_ABSORB, 8'hff);
        queue_byte(CMD_UNUSED, 8'hff);
        queue_byte(CMD_ABSORB_FINISH, 8'hff);
        queue_byte(CMD_ABSORB, 8'h61);
        queue_byte(CMD_ABSORB, 8'h62);
        queue_byte(CMD_ABSORB_FINISH, 8'h63);
        queue_byte(CMD_ABSORB, 8'haa);
        queue_byte(CMD_ABSORB, 8'h55);
        queue_byte(CMD_FINISH, 8'h00);
        wait_drained();

        // Random messages under each idling pattern; the first one nears a block edge.
        run_phase(0, 0, 10, 1'b1);
        run_phase(82, 0, 10, 1'b0);
        run_phase(0, 82, 10, 1'b0);
        run_phase(27, 27, 10, 1'b0);

        // Long receiver hold-off while the sender keeps offering bytes.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_byte(CMD_ABSORB_FINISH, 8'h3c);
        for (int i = 0; i < 10; i++) queue_byte(CMD_ABSORB, 8'($urandom));
        queue_byte(CMD_FINISH, 8'h00);
        hold_seq++;
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!failed && digest_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
